/* hdl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Shared types and constants: envelope phases, register map, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int PHASE_W    = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Envelope phase, also the encoding of the phase result field
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_ATTACK      = 3'd0,
    REG_DECAY       = 3'd1,
    REG_RELEASE     = 3'd2,
    REG_SUSTAIN     = 3'd3,
    REG_KEY_MODE    = 3'd4,
    REG_REPEAT_MODE = 3'd5
  } cfg_reg_t;

  // Trigger mode bits from the register block
  typedef struct packed {
    logic key_trigger_mode;
    logic key_repeat_mode;
  } mode_t;

  // Per-tick sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_HOLD
  } seq_state_t;

  // Multiply-then-divide unit
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN
  } div_state_t;

endpackage

`default_nettype wire

/* hdl/adsr_if.sv */
// ----------------------------------------------------------------------------
// ADSR stream interfaces
// Valid/ready channels for sample ticks in and envelope levels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_sample_if;
  logic valid;
  logic ready;
  logic gate;
  logic key_trigger;
  logic lfo_pulse;

  modport source (output valid, output gate, output key_trigger, output lfo_pulse,
                  input ready);
  modport sink   (input valid, input gate, input key_trigger, input lfo_pulse,
                  output ready);
endinterface

interface adsr_env_if #(parameter int LEVEL_W = 17);
  logic                         valid;
  logic                         ready;
  logic [LEVEL_W-1:0]           level;
  logic [adsr_pkg::PHASE_W-1:0] phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

/* hdl/adsr_cfg.sv */
// ----------------------------------------------------------------------------
// ADSR register block
// APB-style register file for segment lengths, sustain level and trigger modes.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_cfg #(
  parameter int COUNT_WIDTH     = 24,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adsr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [adsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [adsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [COUNT_WIDTH-1:0]          attack_samples,
  output logic [COUNT_WIDTH-1:0]          decay_samples,
  output logic [COUNT_WIDTH-1:0]          release_samples,
  output logic [LEVEL_FRAC_BITS:0]        sustain_level,
  output adsr_pkg::mode_t                 mode
);
  import adsr_pkg::*;

  logic     wr_en;
  cfg_reg_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples        <= '0;
      decay_samples         <= '0;
      release_samples       <= '0;
      sustain_level         <= '0;
      mode.key_trigger_mode <= 1'b1;
      mode.key_repeat_mode  <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:      attack_samples        <= pwdata[COUNT_WIDTH-1:0];
        REG_DECAY:       decay_samples         <= pwdata[COUNT_WIDTH-1:0];
        REG_RELEASE:     release_samples       <= pwdata[COUNT_WIDTH-1:0];
        REG_SUSTAIN:     sustain_level         <= pwdata[LEVEL_FRAC_BITS:0];
        REG_KEY_MODE:    mode.key_trigger_mode <= pwdata[0];
        REG_REPEAT_MODE: mode.key_repeat_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:      prdata = APB_DATA_W'(attack_samples);
      REG_DECAY:       prdata = APB_DATA_W'(decay_samples);
      REG_RELEASE:     prdata = APB_DATA_W'(release_samples);
      REG_SUSTAIN:     prdata = APB_DATA_W'(sustain_level);
      REG_KEY_MODE:    prdata = APB_DATA_W'(mode.key_trigger_mode);
      REG_REPEAT_MODE: prdata = APB_DATA_W'(mode.key_repeat_mode);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/adsr_div.sv */
// ----------------------------------------------------------------------------
// ADSR multiply-divide unit
// Computes floor(a * b / d) with a multiply state (DIV_MUL) and a restoring divider
// that retires one quotient bit per cycle. Quotient must fit in F+1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div #(
  parameter int COUNT_WIDTH     = 24,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [LEVEL_FRAC_BITS:0] mul_a,
  input  logic [COUNT_WIDTH-1:0]   mul_b,
  input  logic [COUNT_WIDTH:0]     divisor,
  output logic                     done,
  output logic [LEVEL_FRAC_BITS:0] quotient
);
  import adsr_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int F     = LEVEL_FRAC_BITS;
  localparam int STEPS = F + 1;
  localparam int CNT_W = $clog2(STEPS);

  div_state_t       state, state_next;
  logic [F:0]       a_q;
  logic [CW-1:0]    b_q;
  logic [CW:0]      den;
  logic [F+CW:0]    prod;
  logic [CW:0]      rem;
  logic [F:0]       q_sh;
  logic [CNT_W-1:0] cnt;
  logic [CW+1:0]    trial;
  logic [CW+1:0]    diff;
  logic             ge;
  logic             load_mul;
  logic             step_en;
  logic             last_step;

  assign prod  = a_q * b_q;
  assign trial = {rem, q_sh[F]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start)     state_next = DIV_MUL;
      DIV_MUL:                 state_next = DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_IDLE;
      default:                 state_next = DIV_IDLE;
    endcase
  end

  // State decodes
  always_comb begin
    load_mul  = (state == DIV_MUL);
    step_en   = (state == DIV_RUN);
    last_step = step_en && (cnt == CNT_W'(STEPS - 1));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= last_step;
      if (load_mul) begin
        cnt <= '0;
      end else if (step_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Operands, product and one quotient bit per step
  always_ff @(posedge clk) begin
    if (start && state == DIV_IDLE) begin
      a_q <= mul_a;
      b_q <= mul_b;
      den <= divisor;
    end
    if (load_mul) begin
      rem  <= {1'b0, prod[F+CW:F+1]};
      q_sh <= prod[F:0];
    end else if (step_en) begin
      rem  <= ge ? diff[CW:0] : trial[CW:0];
      q_sh <= {q_sh[F-1:0], ge};
    end
  end

  assign quotient = q_sh;

endmodule

`default_nettype wire

/* hdl/adsr_envelope_generator.sv */
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack/decay/sustain/release envelope, one level per sample tick.
// Ramp ticks pass through the shared multiply-divide unit (multiply, then
// divide steps) and wait in SEQ_HOLD for the output register; idle and
// sustain ticks go straight to SEQ_HOLD. A new tick is taken only after the
// previous result is loaded; the divider retires one quotient bit per cycle.
// Reset (rst, synchronous): phase idle, counters zero, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator #(
  parameter int COUNT_WIDTH     = 24,
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  adsr_sample_if.sink                     sample,
  adsr_env_if.source                      env,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adsr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [adsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [adsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import adsr_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int F  = LEVEL_FRAC_BITS;
  localparam logic [F:0]    LVL_ONE = {1'b1, {F{1'b0}}};
  localparam logic [CW-1:0] CNT_MAX = '1;

  // Registers
  logic [CW-1:0] attack_samples;
  logic [CW-1:0] decay_samples;
  logic [CW-1:0] release_samples;
  logic [F:0]    sustain_level;
  mode_t         mode;

  // Envelope state
  phase_t        cur_phase;
  logic [CW-1:0] elapsed;
  logic [CW-1:0] remaining;

  // Tick evaluation
  logic          trig;
  logic [F:0]    sus;
  phase_t        tick_phase;
  logic [CW-1:0] tick_elapsed;
  logic [CW-1:0] tick_remaining;
  logic [CW-1:0] elapsed_next;
  logic [CW-1:0] remaining_next;
  logic          need_div;
  logic          invert;
  logic [F:0]    mul_a;
  logic [CW-1:0] mul_b;
  logic [CW:0]   divisor;
  logic [F:0]    direct_level;

  // Sequencer and result
  seq_state_t    seq, seq_next;
  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [F:0]    quotient;
  logic          out_free;
  logic          out_load;
  logic          res_invert;
  logic [F:0]    res_level;
  logic          out_valid;
  logic [F:0]    out_level;
  phase_t        out_phase;

  adsr_cfg #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .attack_samples (attack_samples),
    .decay_samples  (decay_samples),
    .release_samples(release_samples),
    .sustain_level  (sustain_level),
    .mode           (mode)
  );

  adsr_div #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quotient)
  );

  // Clamp sustain to full scale, pick the trigger source
  assign sus  = (sustain_level > LVL_ONE) ? LVL_ONE : sustain_level;
  assign trig = mode.key_trigger_mode ? sample.key_trigger :
                mode.key_repeat_mode  ? (sample.gate && sample.lfo_pulse) :
                                        sample.lfo_pulse;

  // Chain phase changes in trigger, attack, decay, release entry, release order
  always_comb begin
    phase_t        ph;
    logic [CW-1:0] e;
    logic [CW-1:0] r;
    ph = cur_phase;
    e  = elapsed;
    r  = remaining;
    if (trig) begin
      ph = PH_ATTACK;
      e  = '0;
      r  = attack_samples;
    end
    if (ph == PH_ATTACK && r == '0) begin
      ph = PH_DECAY;
      e  = '0;
      r  = decay_samples;
    end
    if (ph == PH_DECAY && r == '0) begin
      ph = PH_SUSTAIN;
    end
    if ((mode.key_trigger_mode && !sample.gate &&
         (ph == PH_ATTACK || ph == PH_DECAY || ph == PH_SUSTAIN)) ||
        (!mode.key_trigger_mode && ph == PH_SUSTAIN)) begin
      ph = PH_RELEASE;
      e  = '0;
      r  = release_samples;
    end
    if (ph == PH_RELEASE && r == '0) begin
      ph = PH_IDLE;
    end
    tick_phase     = ph;
    tick_elapsed   = e;
    tick_remaining = r;
  end

  // Level source for the final phase, and counter advance
  always_comb begin
    need_div       = 1'b0;
    invert         = 1'b0;
    mul_a          = LVL_ONE;
    mul_b          = tick_elapsed;
    direct_level   = '0;
    divisor        = {1'b0, tick_elapsed} + {1'b0, tick_remaining};
    elapsed_next   = tick_elapsed;
    remaining_next = tick_remaining;
    unique case (tick_phase)
      PH_ATTACK: begin
        need_div = 1'b1;
      end
      PH_DECAY: begin
        need_div = 1'b1;
        invert   = 1'b1;
        mul_a    = LVL_ONE - sus;
      end
      PH_SUSTAIN: begin
        direct_level = sus;
      end
      PH_RELEASE: begin
        need_div = 1'b1;
        mul_a    = sus;
        mul_b    = tick_remaining;
      end
      default: begin
        direct_level = '0;
      end
    endcase
    if (tick_phase != PH_IDLE && tick_phase != PH_SUSTAIN) begin
      if (tick_elapsed != CNT_MAX) begin
        elapsed_next = tick_elapsed + 1'b1;
      end
      if (tick_remaining != '0) begin
        remaining_next = tick_remaining - 1'b1;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: if (accept)   seq_next = need_div ? SEQ_DIV : SEQ_HOLD;
      SEQ_DIV:  if (div_done) seq_next = SEQ_HOLD;
      SEQ_HOLD: if (out_free) seq_next = SEQ_IDLE;
      default:                seq_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    sample.ready = (seq == SEQ_IDLE);
    accept       = sample.valid && sample.ready;
    div_start    = accept && need_div;
    out_free     = !out_valid || env.ready;
    out_load     = (seq == SEQ_HOLD) && out_free;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      cur_phase <= PH_IDLE;
      elapsed   <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (accept) begin
        cur_phase <= tick_phase;
        elapsed   <= elapsed_next;
        remaining <= remaining_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (env.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold the level until the output register frees up
  always_ff @(posedge clk) begin
    if (accept) begin
      res_invert <= invert;
      res_level  <= direct_level;
    end else if (seq == SEQ_DIV && div_done) begin
      res_level <= res_invert ? (LVL_ONE - quotient) : quotient;
    end
    if (out_load) begin
      out_level <= res_level;
      out_phase <= cur_phase;
    end
  end

  assign env.valid = out_valid;
  assign env.level = out_level;
  assign env.phase = out_phase;

endmodule

`default_nettype wire

/* hdl/adsr_checker.sv */
// ----------------------------------------------------------------------------
// ADSR envelope generator checker
// Port-level properties of the envelope stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_checker #(
  parameter int LEVEL_FRAC_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [LEVEL_FRAC_BITS:0]     level,
  input logic [adsr_pkg::PHASE_W-1:0] phase
);
  import adsr_pkg::*;

  localparam logic [LEVEL_FRAC_BITS:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(phase))
    else $error("envelope result changed while stalled");

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LVL_ONE)
    else $error("envelope level above full scale");

  // Idle phase always reports zero level
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_IDLE |-> level == '0)
    else $error("nonzero level in idle phase");

  // Block is busy after taking a tick
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("tick taken while previous tick in flight");

endmodule

bind adsr_envelope_generator adsr_checker #(
  .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (sample.valid),
  .in_ready (sample.ready),
  .out_valid(env.valid),
  .out_ready(env.ready),
  .level    (env.level),
  .phase    (env.phase)
);

`default_nettype wire
